// ===== sv/mpva_pkg.sv =====
// ----------------------------------------------------------------------------
// mpva_pkg
// Shared types and constants of the MIDI parser and voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpva_pkg;

    localparam int VOICES  = 6;
    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MASK_W  = 6;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 7;

    localparam logic [3:0] NIB_SYSTEM   = 4'hF;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [3:0] NIB_RESET    = NIB_NOTE_ON;

    typedef enum logic [1:0] {
        EV_NOTE_ON  = 2'd0,
        EV_NOTE_OFF = 2'd1,
        EV_CTRL     = 2'd2,
        EV_OTHER    = 2'd3
    } mpva_kind_t;

    typedef enum logic [1:0] {
        POS_STATUS = 2'd0,
        POS_FIRST  = 2'd1,
        POS_SECOND = 2'd2
    } mpva_pos_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } mpva_beat_t;

endpackage

`default_nettype wire

// ===== sv/mpva_if.sv =====
// ----------------------------------------------------------------------------
// mpva_byte_if / mpva_event_if
// Valid/ready channels for raw MIDI bytes and decoded events.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpva_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpva_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [2:0] voice_index;
    logic [6:0] key_or_control;
    logic [6:0] data_value;
    logic [5:0] active_mask;

    modport source (output valid, output event_kind, output voice_index,
                    output key_or_control, output data_value, output active_mask,
                    input ready);
    modport sink   (input valid, input event_kind, input voice_index,
                    input key_or_control, input data_value, input active_mask,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/mpva_in_reg.sv =====
// ----------------------------------------------------------------------------
// mpva_in_reg
// Input register: captures one MIDI byte beat and holds it for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mpva_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    mpva_byte_if.sink              rx,
    input  wire logic              take,
    output mpva_pkg::mpva_beat_t   beat
);
    import mpva_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign rx.ready = !valid_reg || take;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/mpva_engine.sv =====
// ----------------------------------------------------------------------------
// mpva_engine
// Running-status parser, round-robin voice table and event output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpva_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  mpva_pkg::mpva_beat_t   beat,
    output logic                   take,
    mpva_event_if.source           evt
);
    import mpva_pkg::*;

    mpva_pos_t          pos_reg, pos_next;
    logic [3:0]         status_reg, status_next;
    logic [DATA_W-1:0]  first_reg, first_next;
    logic [DATA_W-1:0]  key_reg [VOICES];
    logic [DATA_W-1:0]  key_next [VOICES];
    logic [VOICES-1:0]  snd_reg, snd_next;
    logic [VIDX_W-1:0]  nv_reg, nv_next;

    logic               out_valid_reg, out_valid_next;
    mpva_kind_t         kind_reg, kind_next;
    logic [INDEX_W-1:0] vidx_reg, vidx_next;
    logic [DATA_W-1:0]  key_out_reg;
    logic [DATA_W-1:0]  data_out_reg, data_out_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;

    logic [3:0]         nib;
    logic               sys_byte;
    mpva_pos_t          pos_eff;
    logic               emit;
    logic               out_free;
    logic               fire;
    logic [VIDX_W+INDEX_W-1:0] nv_ext;
    logic [VOICES+MASK_W-1:0]  snd_ext;

    assign nib      = beat.data[7:4];
    assign sys_byte = (nib == NIB_SYSTEM);
    assign pos_eff  = beat.data[7] ? POS_STATUS : pos_reg;
    assign emit     = !sys_byte && (pos_eff == POS_SECOND);
    assign out_free = !out_valid_reg || evt.ready;
    assign take     = beat.valid && (!emit || out_free);
    assign fire     = take && emit;
    assign nv_ext   = {{INDEX_W{1'b0}}, nv_reg};

    always_comb
    begin
        pos_next      = pos_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        key_next      = key_reg;
        snd_next      = snd_reg;
        nv_next       = nv_reg;
        kind_next     = EV_OTHER;
        vidx_next     = '0;
        data_out_next = beat.data[DATA_W-1:0];
        if (take && !sys_byte)
        begin
            unique case (pos_eff)
                POS_STATUS:
                begin
                    status_next = nib;
                    pos_next    = POS_FIRST;
                end
                POS_FIRST:
                begin
                    first_next = beat.data[DATA_W-1:0];
                    pos_next   = POS_SECOND;
                end
                POS_SECOND:
                begin
                    pos_next = POS_FIRST;
                    priority if (status_reg == NIB_NOTE_ON)
                    begin
                        key_next[nv_reg] = first_reg;
                        snd_next[nv_reg] = 1'b1;
                        vidx_next        = nv_ext[INDEX_W-1:0];
                        nv_next          = (nv_reg == VIDX_W'(VOICES - 1)) ?
                                           '0 : nv_reg + VIDX_W'(1);
                        kind_next        = EV_NOTE_ON;
                    end
                    else if (status_reg == NIB_NOTE_OFF)
                    begin
                        for (int v = 0; v < VOICES; v++)
                        begin
                            if (key_reg[v] == first_reg)
                            begin
                                key_next[v] = '0;
                                snd_next[v] = 1'b0;
                            end
                        end
                        kind_next = EV_NOTE_OFF;
                    end
                    else if (status_reg == NIB_CTRL)
                    begin
                        kind_next = EV_CTRL;
                    end
                    else
                    begin
                        kind_next = EV_OTHER;
                    end
                end
                default:
                begin
                    pos_next = POS_FIRST;
                end
            endcase
        end
    end

    assign snd_ext   = {{MASK_W{1'b0}}, snd_next};
    assign mask_next = snd_ext[MASK_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_STATUS;
            status_reg    <= NIB_RESET;
            first_reg     <= '0;
            snd_reg       <= '0;
            nv_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                key_reg[v] <= '0;
            end
        end
        else
        begin
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            first_reg     <= first_next;
            snd_reg       <= snd_next;
            nv_reg        <= nv_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg     <= kind_next;
            vidx_reg     <= vidx_next;
            key_out_reg  <= first_reg;
            data_out_reg <= data_out_next;
            mask_reg     <= mask_next;
        end
    end

    assign evt.valid          = out_valid_reg;
    assign evt.event_kind     = kind_reg;
    assign evt.voice_index    = vidx_reg;
    assign evt.key_or_control = key_out_reg;
    assign evt.data_value     = data_out_reg;
    assign evt.active_mask    = mask_reg;

    a_nv_range: assert property (@(posedge clk) disable iff (!rst_n)
        nv_reg < VIDX_W'(VOICES))
        else $error("round-robin pointer out of range");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("completed message not presented");

    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> out_free)
        else $error("event overwritten while stalled");

    a_vidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg != EV_NOTE_ON) |-> (vidx_reg == '0))
        else $error("voice index set on non note-on event");

endmodule

`default_nettype wire

// ===== sv/midi_parser_voice_allocator_core.sv =====
// ----------------------------------------------------------------------------
// midi_parser_voice_allocator_core
// MIDI byte parser with running status and round-robin voice allocation.
//
// Channels: rx takes one raw MIDI byte per beat; evt gives one event beat for
// each completed three-byte message (note on, note off, control change or
// other), with the voice taken, both data bytes and the sounding-voice mask.
// System bytes and bytes that only advance the parser give no event.
// The last byte beat of a message passes the input register and then the
// event register before its event shows on evt. Throughput: one byte per
// cycle while no message waits on a held evt, as a two-stage pipeline; the
// voice table is updated in one pass with all key compares in parallel.
// Reset: parser awaits a status byte with note on assumed as running status,
// all voices silent, the round-robin pointer at voice zero.
// Stall: while evt is held, bytes that give no event still pass; a byte that
// completes a message waits in the input register and rx.ready drops once
// that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_parser_voice_allocator_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mpva_byte_if.sink     rx,
    mpva_event_if.source  evt
);
    import mpva_pkg::*;

    mpva_beat_t beat;
    logic       take;

    mpva_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .beat  (beat)
    );

    mpva_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (take),
        .evt   (evt)
    );

endmodule

`default_nettype wire
